@@ src/hhw_pkg.sv @@
package hhw_pkg;

  // Number of watched components and bits compared per heartbeat counter.
  localparam int unsigned Components = 4;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned SlotBits   = 16;
  localparam int unsigned IdxW       = (Components > 1) ? $clog2(Components) : 1;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned MemW   = 24;
  localparam int unsigned RunW   = 8;
  localparam int unsigned BeatsW = 64;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned InDataW  = 128;
  localparam int unsigned OutDataW = 64;

  localparam logic [MemW-1:0]  MemFloorRst     = MemW'(12 * 1024);
  localparam logic [RunW-1:0]  BreachLimitRst  = RunW'(5);
  localparam logic [TimeW-1:0] StallLimitRst   = TimeW'(20000);
  localparam logic [TimeW-1:0] FastPassRst     = TimeW'(30 * 1000);
  localparam logic [TimeW-1:0] CeilingPassRst  = TimeW'(60 * 1000);
  localparam logic [MemW-1:0]  MemAllOnes      = {MemW{1'b1}};
  localparam logic [RunW-1:0]  RunMax          = {RunW{1'b1}};

  typedef enum logic [2:0] {
    VerdictRunning = 3'd0,
    VerdictFast    = 3'd1,
    VerdictCeiling = 3'd2,
    VerdictMemory  = 3'd3,
    VerdictStall   = 3'd4
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMemFloor    = 3'd0,
    CfgBreachLimit = 3'd1,
    CfgStallLimit  = 3'd2,
    CfgFastPass    = 3'd3,
    CfgCeilingPass = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ReqArm    = 1'b0,
    ReqSample = 1'b1
  } req_e;

  typedef struct packed {
    logic [MemW-1:0]  memory_floor;
    logic [RunW-1:0]  breach_limit;
    logic [TimeW-1:0] stall_limit_ms;
    logic [TimeW-1:0] fast_pass_ms;
    logic [TimeW-1:0] ceiling_pass_ms;
  } cfg_t;

  typedef struct packed {
    req_e               req_type;
    logic [TimeW-1:0]   now_ms;
    logic [MemW-1:0]    free_memory;
    logic [BeatsW-1:0]  beat_counts;
    logic               env_ok;
  } item_t;

  typedef struct packed {
    verdict_e           verdict;
    logic [1:0]         stalled_index;
    logic [MemW-1:0]    lowest_memory;
    logic [TimeW-1:0]   elapsed_ms;
  } result_t;

endpackage

@@ src/hhw_cfg.sv @@
module hhw_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [hhw_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [hhw_pkg::CfgDataW-1:0]       cfg_data_i,
  output hhw_pkg::cfg_t                      cfg_o
);

  hhw_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (hhw_pkg::cfg_idx_e'(cfg_index_i))
        hhw_pkg::CfgMemFloor:    cfg_d.memory_floor    = cfg_data_i[hhw_pkg::MemW-1:0];
        hhw_pkg::CfgBreachLimit: cfg_d.breach_limit    = cfg_data_i[hhw_pkg::RunW-1:0];
        hhw_pkg::CfgStallLimit:  cfg_d.stall_limit_ms  = cfg_data_i[hhw_pkg::TimeW-1:0];
        hhw_pkg::CfgFastPass:    cfg_d.fast_pass_ms    = cfg_data_i[hhw_pkg::TimeW-1:0];
        hhw_pkg::CfgCeilingPass: cfg_d.ceiling_pass_ms = cfg_data_i[hhw_pkg::TimeW-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.memory_floor    <= hhw_pkg::MemFloorRst;
      cfg_q.breach_limit    <= hhw_pkg::BreachLimitRst;
      cfg_q.stall_limit_ms  <= hhw_pkg::StallLimitRst;
      cfg_q.fast_pass_ms    <= hhw_pkg::FastPassRst;
      cfg_q.ceiling_pass_ms <= hhw_pkg::CeilingPassRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/hhw_core.sv @@
module hhw_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  hhw_pkg::item_t    item_i,
  input  hhw_pkg::cfg_t     cfg_i,
  output hhw_pkg::result_t  result_o
);

  localparam int unsigned N = hhw_pkg::Components;

  logic [hhw_pkg::CountBits-1:0] prev_q [N];
  logic [hhw_pkg::CountBits-1:0] prev_d [N];
  logic [hhw_pkg::TimeW-1:0]     chg_q  [N];
  logic [hhw_pkg::TimeW-1:0]     chg_d  [N];
  logic [hhw_pkg::TimeW-1:0]     arm_q, arm_d;
  logic [hhw_pkg::RunW-1:0]      run_q, run_d;
  logic [hhw_pkg::MemW-1:0]      low_q, low_d;
  hhw_pkg::verdict_e             held_q, held_d;
  logic [hhw_pkg::IdxW-1:0]      idx_q, idx_d;

  logic [hhw_pkg::CountBits-1:0] beat    [N];
  logic [N-1:0]                  changed;
  logic [N-1:0]                  stale;
  logic [N-1:0]                  upd;
  logic                          blocked;
  logic [hhw_pkg::IdxW-1:0]      stall_idx;
  logic [hhw_pkg::RunW-1:0]      run_inc;
  logic                          breach;
  logic                          mem_trip;
  logic [hhw_pkg::TimeW-1:0]     elapsed;
  hhw_pkg::verdict_e             sample_verdict;

  // Per-component change / stale detection.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      beat[i]    = item_i.beat_counts[hhw_pkg::SlotBits*i +: hhw_pkg::CountBits];
      changed[i] = (beat[i] != prev_q[i]);
      stale[i]   = !changed[i] && ((item_i.now_ms - chg_q[i]) > cfg_i.stall_limit_ms);
    end
  end

  // Breach run and memory trip.
  assign breach   = (item_i.free_memory < cfg_i.memory_floor);
  assign run_inc  = (run_q == hhw_pkg::RunMax) ? run_q : run_q + 1'b1;
  assign mem_trip = breach && (run_inc >= cfg_i.breach_limit);
  assign elapsed  = item_i.now_ms - arm_q;

  // First stale component wins; only components before it take a new change time, and none on a memory trip.
  always_comb begin
    blocked   = 1'b0;
    stall_idx = '0;
    upd       = '0;
    for (int i = 0; i < N; i++) begin
      upd[i] = changed[i] && !blocked && !mem_trip;
      if (!blocked && stale[i]) begin
        stall_idx = hhw_pkg::IdxW'(i);
      end
      blocked = blocked | stale[i];
    end
  end

  always_comb begin
    if (mem_trip) begin
      sample_verdict = hhw_pkg::VerdictMemory;
    end else if (blocked) begin
      sample_verdict = hhw_pkg::VerdictStall;
    end else if ((elapsed >= cfg_i.fast_pass_ms) && item_i.env_ok) begin
      sample_verdict = hhw_pkg::VerdictFast;
    end else if (elapsed >= cfg_i.ceiling_pass_ms) begin
      sample_verdict = hhw_pkg::VerdictCeiling;
    end else begin
      sample_verdict = hhw_pkg::VerdictRunning;
    end
  end

  // Next state.
  always_comb begin
    prev_d = prev_q;
    chg_d  = chg_q;
    arm_d  = arm_q;
    run_d  = run_q;
    low_d  = low_q;
    held_d = held_q;
    idx_d  = idx_q;
    if (step_i) begin
      if (item_i.req_type == hhw_pkg::ReqArm) begin
        for (int i = 0; i < N; i++) begin
          prev_d[i] = beat[i];
          chg_d[i]  = item_i.now_ms;
        end
        arm_d  = item_i.now_ms;
        run_d  = '0;
        low_d  = hhw_pkg::MemAllOnes;
        held_d = hhw_pkg::VerdictRunning;
        idx_d  = '0;
      end else if (held_q == hhw_pkg::VerdictRunning) begin
        if (item_i.free_memory < low_q) begin
          low_d = item_i.free_memory;
        end
        run_d = breach ? run_inc : '0;
        for (int i = 0; i < N; i++) begin
          if (upd[i]) begin
            prev_d[i] = beat[i];
            chg_d[i]  = item_i.now_ms;
          end
        end
        held_d = sample_verdict;
        idx_d  = (sample_verdict == hhw_pkg::VerdictStall) ? stall_idx : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        prev_q[i] <= '0;
        chg_q[i]  <= '0;
      end
      arm_q  <= '0;
      run_q  <= '0;
      low_q  <= hhw_pkg::MemAllOnes;
      held_q <= hhw_pkg::VerdictRunning;
      idx_q  <= '0;
    end else begin
      prev_q <= prev_d;
      chg_q  <= chg_d;
      arm_q  <= arm_d;
      run_q  <= run_d;
      low_q  <= low_d;
      held_q <= held_d;
      idx_q  <= idx_d;
    end
  end

  // Result reflects state after this item.
  assign result_o.verdict       = held_d;
  assign result_o.stalled_index = (held_d == hhw_pkg::VerdictStall) ? 2'(idx_d) : 2'd0;
  assign result_o.lowest_memory = low_d;
  assign result_o.elapsed_ms    = item_i.now_ms - arm_d;

  // A decided verdict sticks until an arm request.
  a_held_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != hhw_pkg::VerdictRunning) && !(step_i && item_i.req_type == hhw_pkg::ReqArm)
    |=> $stable(held_q) && $stable(low_q) && $stable(run_q))
    else $error("held verdict changed without arm");

  // Arm captures the baseline time.
  a_arm_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.req_type == hhw_pkg::ReqArm
    |=> (arm_q == $past(item_i.now_ms)) && (held_q == hhw_pkg::VerdictRunning))
    else $error("arm did not capture baseline");

  // Stall index only carried with a stall verdict.
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != hhw_pkg::VerdictStall) |-> (idx_q == '0))
    else $error("stall index set without stall verdict");

  // Low mark never rises except on arm.
  a_low_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_i && item_i.req_type == hhw_pkg::ReqArm) |=> (low_q <= $past(low_q)))
    else $error("low memory mark rose");

endmodule

@@ src/heartbeat_health_watchdog.sv @@
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid_i/tready_o       tuser: req_type; tdata: sample fields
// m_axis    out  m_axis_tvalid_o/tready_i       tdata: verdict, index, low mark, elapsed
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// One request per cycle unless m_axis stalls: a request waits in the input register,
// is evaluated in one pass and lands in the output register.
// Throughput is set by the output register; when it is full and m_axis_tready_i is
// low, one more request is still taken into the input register, then tready drops.
// rst_ni is asynchronous, active low; config returns to its defaults, no clearing pass.
// Config is always accepted and takes effect on the next cycle.
module heartbeat_health_watchdog (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample / arm requests
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [31:0] now_ms, [55:32] free_memory, [119:56] beat_counts, [120] env_ok, rest 0
  input  logic [hhw_pkg::InDataW-1:0]       s_axis_tdata_i,
  // [0] req_type
  input  logic                              s_axis_tuser_i,
  // results
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [2:0] verdict, [4:3] stalled_index, [28:5] lowest_memory, [60:29] elapsed_ms, rest 0
  output logic [hhw_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // config write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [hhw_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [hhw_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned ResW = $bits(hhw_pkg::result_t);

  hhw_pkg::cfg_t    cfg;
  hhw_pkg::item_t   in_item_d, in_item_q;
  hhw_pkg::result_t result;
  logic             in_valid_d, in_valid_q;
  logic             out_valid_d, out_valid_q;
  logic [hhw_pkg::OutDataW-1:0] out_data_d, out_data_q;
  logic             in_fire, out_free, step;

  assign cfg_ready_o = 1'b1;

  hhw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Unpack the request.
  always_comb begin
    in_item_d             = in_item_q;
    if (in_fire) begin
      in_item_d.req_type    = hhw_pkg::req_e'(s_axis_tuser_i);
      in_item_d.now_ms      = s_axis_tdata_i[31:0];
      in_item_d.free_memory = s_axis_tdata_i[55:32];
      in_item_d.beat_counts = s_axis_tdata_i[119:56];
      in_item_d.env_ok      = s_axis_tdata_i[120];
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  hhw_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Pack the result, verdict in the low bits.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (step) begin
      out_valid_d = 1'b1;
      out_data_d  = {{(hhw_pkg::OutDataW-ResW){1'b0}},
                     result.elapsed_ms, result.lowest_memory,
                     result.stalled_index, result.verdict};
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_item_q  <= in_item_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
